@@ rtl/mbg_pkg.sv @@
package mbg_pkg;

    localparam int MAX_WIDTH_DEF  = 32;
    localparam int MAX_HEIGHT_DEF = 32;

    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int OP_W      = 2;
    localparam int COORD_W   = 5;
    localparam int RAND_W    = 8;
    localparam int EVENT_W   = 3;
    localparam int DIR_W     = 2;
    localparam int WALL_W    = 4;

    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 6'd32;
    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_HEIGHT = 1'b0,
        CFG_GRID_WIDTH  = 1'b1
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_STARTED     = 3'd0,
        EV_CARVED      = 3'd1,
        EV_BACKTRACKED = 3'd2,
        EV_FINISHED    = 3'd3,
        EV_READ        = 3'd4
    } event_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCLEAR,
        ST_START_WR,
        ST_FIN_OUT,
        ST_READ_RD,
        ST_READ_OUT,
        ST_PROBE,
        ST_PICK,
        ST_CARVE,
        ST_POP
    } state_t;

    typedef struct packed {
        logic   in_ready;
        logic   capture;
        logic   clr_step;
        logic   start_init;
        logic   probe;
        logic   cell_rd;
        logic   pick;
        logic   carve;
        logic   pop;
        logic   out_load;
        event_t out_event;
    } cmd_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            clr_done;
        logic            depth_zero;
        logic            probe_last;
        logic            can_carve;
        logic            out_free;
    } status_t;

endpackage

@@ rtl/mbg_in_if.sv @@
interface mbg_in_if;
    logic                         valid;
    logic                         ready;
    logic [mbg_pkg::OP_W-1:0]     operation;
    logic [mbg_pkg::COORD_W-1:0]  cell_x;
    logic [mbg_pkg::COORD_W-1:0]  cell_y;
    logic [mbg_pkg::RAND_W-1:0]   random_value;

    modport source (output valid, output operation, output cell_x, output cell_y,
                    output random_value, input ready);
    modport sink (input valid, input operation, input cell_x, input cell_y,
                  input random_value, output ready);
endinterface

@@ rtl/mbg_out_if.sv @@
interface mbg_out_if;
    logic                         valid;
    logic                         ready;
    logic [mbg_pkg::EVENT_W-1:0]  event_res;
    logic [mbg_pkg::COORD_W-1:0]  from_x;
    logic [mbg_pkg::COORD_W-1:0]  from_y;
    logic [mbg_pkg::COORD_W-1:0]  to_x;
    logic [mbg_pkg::COORD_W-1:0]  to_y;
    logic [mbg_pkg::DIR_W-1:0]    direction;
    logic [mbg_pkg::WALL_W-1:0]   wall_bits;

    modport source (output valid, output event_res, output from_x, output from_y,
                    output to_x, output to_y, output direction, output wall_bits,
                    input ready);
    modport sink (input valid, input event_res, input from_x, input from_y,
                  input to_x, input to_y, input direction, input wall_bits,
                  output ready);
endinterface

@@ rtl/mbg_ctrl.sv @@
module mbg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  mbg_pkg::status_t status,
    output mbg_pkg::cmd_t    cmd
);

    mbg_pkg::state_t state_reg;
    mbg_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbg_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.out_event = mbg_pkg::EV_STARTED;
        state_next    = state_reg;
        case (state_reg)
            mbg_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (status.op)
                        mbg_pkg::OP_START: state_next = mbg_pkg::ST_SCLEAR;
                        mbg_pkg::OP_STEP:
                        begin
                            if (status.depth_zero)
                            begin
                                state_next = mbg_pkg::ST_FIN_OUT;
                            end
                            else
                            begin
                                state_next = mbg_pkg::ST_PROBE;
                            end
                        end
                        mbg_pkg::OP_READ:  state_next = mbg_pkg::ST_READ_RD;
                        default:           state_next = mbg_pkg::ST_IDLE;
                    endcase
                end
            end
            mbg_pkg::ST_SCLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = mbg_pkg::ST_START_WR;
                end
            end
            mbg_pkg::ST_START_WR:
            begin
                if (status.out_free)
                begin
                    cmd.start_init = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_event  = mbg_pkg::EV_STARTED;
                    state_next     = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_FIN_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_event = mbg_pkg::EV_FINISHED;
                    state_next    = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_READ_RD:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = mbg_pkg::ST_READ_OUT;
            end
            mbg_pkg::ST_READ_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_event = mbg_pkg::EV_READ;
                    state_next    = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (status.probe_last)
                begin
                    state_next = mbg_pkg::ST_PICK;
                end
            end
            mbg_pkg::ST_PICK:
            begin
                if (status.can_carve)
                begin
                    cmd.pick   = 1'b1;
                    state_next = mbg_pkg::ST_CARVE;
                end
                else
                begin
                    state_next = mbg_pkg::ST_POP;
                end
            end
            mbg_pkg::ST_CARVE:
            begin
                if (status.out_free)
                begin
                    cmd.carve     = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_event = mbg_pkg::EV_CARVED;
                    state_next    = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_POP:
            begin
                if (status.out_free)
                begin
                    cmd.pop       = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.out_event = mbg_pkg::EV_BACKTRACKED;
                    state_next    = mbg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/mbg_dpath.sv @@
module mbg_dpath #(
    parameter int MAX_WIDTH  = mbg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mbg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]     cfg_data,
    mbg_in_if.sink                        item,
    mbg_out_if.source                     result,
    input  mbg_pkg::cmd_t                 cmd,
    output mbg_pkg::status_t              status
);

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int AW        = XW + YW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int CELLS     = MAX_WIDTH * MAX_HEIGHT;
    localparam int SIW       = $clog2(CELLS);
    localparam int DW        = $clog2(CELLS + 1);
    localparam int CW        = mbg_pkg::CFG_W;
    localparam int PW        = mbg_pkg::COORD_W;
    localparam int WW        = mbg_pkg::WALL_W;
    localparam int RW        = mbg_pkg::RAND_W;
    localparam int EW        = WW + 1;
    localparam logic [2:0] PROBE_CUR = 3'd4;

    function automatic logic [1:0] mod3(input logic [RW-1:0] r);
        logic [3:0] s;
        s = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
        if (s >= 4'd12)
        begin
            s = s - 4'd12;
        end
        else if (s >= 4'd9)
        begin
            s = s - 4'd9;
        end
        else if (s >= 4'd6)
        begin
            s = s - 4'd6;
        end
        else if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        return s[1:0];
    endfunction

    function automatic logic [1:0] mod_small(input logic [RW-1:0] r, input logic [2:0] n);
        logic [1:0] m;
        case (n)
            3'd1:    m = 2'd0;
            3'd2:    m = {1'b0, r[0]};
            3'd3:    m = mod3(r);
            3'd4:    m = r[1:0];
            default: m = 2'd0;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] nth_set(input logic [3:0] m, input logic [1:0] k);
        logic [1:0] cnt;
        logic [1:0] sel;
        cnt = '0;
        sel = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (m[i])
            begin
                if (cnt == k)
                begin
                    sel = 2'(i);
                end
                cnt = cnt + 2'd1;
            end
        end
        return sel;
    endfunction

    // configuration
    logic [CW-1:0] grid_height_reg;
    logic [CW-1:0] grid_width_reg;
    logic [CW-1:0] eff_w;
    logic [CW-1:0] eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg <= mbg_pkg::GRID_HEIGHT_RESET;
            grid_width_reg  <= mbg_pkg::GRID_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbg_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                mbg_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w = (grid_width_reg == '0) ? CW'(1) :
                   (int'(grid_width_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : grid_width_reg;
    assign eff_h = (grid_height_reg == '0) ? CW'(1) :
                   (int'(grid_height_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : grid_height_reg;

    // input capture with clamping
    logic [CW-1:0] in_x_ext;
    logic [CW-1:0] in_y_ext;
    logic [CW-1:0] in_x_cl;
    logic [CW-1:0] in_y_cl;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [RW-1:0] rnd_reg;

    assign in_x_ext = CW'(item.cell_x);
    assign in_y_ext = CW'(item.cell_y);
    assign in_x_cl  = (in_x_ext >= eff_w) ? eff_w - CW'(1) : in_x_ext;
    assign in_y_cl  = (in_y_ext >= eff_h) ? eff_h - CW'(1) : in_y_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg   <= XW'(in_x_cl);
            y_reg   <= YW'(in_y_cl);
            rnd_reg <= item.random_value;
        end
    end

    // control registers
    logic [AW-1:0] clr_reg;
    logic [2:0]    probe_reg;
    logic [DW-1:0] depth_reg;
    logic [AW-1:0] top_reg;
    logic          out_valid_reg;

    // datapath registers
    logic [3:0]    free_reg;
    mbg_pkg::dir_t dir_reg;
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] stk_rd_reg;

    logic [XW-1:0] top_x;
    logic [YW-1:0] top_y;
    logic [XW-1:0] nb_x;
    logic [YW-1:0] nb_y;
    logic [1:0]    nsel;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] start_addr;
    logic [3:0]    in_grid;
    logic [1:0]    pidx;
    logic [2:0]    free_cnt;
    logic [1:0]    pick_idx;
    logic [1:0]    dir_pick;

    assign top_x      = top_reg[XW-1:0];
    assign top_y      = top_reg[AW-1:XW];
    assign start_addr = {y_reg, x_reg};
    assign nsel       = cmd.carve ? dir_reg : probe_reg[1:0];

    always_comb
    begin
        nb_x = top_x;
        nb_y = top_y;
        case (nsel)
            mbg_pkg::DIR_LEFT:  nb_x = top_x - XW'(1);
            mbg_pkg::DIR_RIGHT: nb_x = top_x + XW'(1);
            mbg_pkg::DIR_UP:    nb_y = top_y - YW'(1);
            mbg_pkg::DIR_DOWN:  nb_y = top_y + YW'(1);
            default: ;
        endcase
    end

    assign nb_addr = {nb_y, nb_x};

    assign in_grid[0] = (top_x != '0);
    assign in_grid[1] = (int'(top_x) + 1 < int'(eff_w));
    assign in_grid[2] = (top_y != '0);
    assign in_grid[3] = (int'(top_y) + 1 < int'(eff_h));

    assign pidx     = 2'(probe_reg - 3'd1);
    assign free_cnt = {2'b00, free_reg[0]} + {2'b00, free_reg[1]}
                    + {2'b00, free_reg[2]} + {2'b00, free_reg[3]};
    assign pick_idx = mod_small(rnd_reg, free_cnt);
    assign dir_pick = nth_set(free_reg, pick_idx);

    // cell memory: visited bit above four open-wall bits
    logic [EW-1:0] cell_mem [MEM_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.start_init)
        begin
            mem_we    = 1'b1;
            mem_waddr = start_addr;
            mem_wdata = {1'b1, WW'(0)};
        end
        else if (cmd.pick)
        begin
            mem_we    = 1'b1;
            mem_waddr = top_reg;
            mem_wdata = {1'b1, rd_data_reg[WW-1:0] | (WW'(1) << dir_pick)};
        end
        else if (cmd.carve)
        begin
            mem_we    = 1'b1;
            mem_waddr = nb_addr;
            mem_wdata = {1'b1, WW'(1) << (dir_reg ^ 2'd1)};
        end
    end

    assign mem_re    = cmd.probe | cmd.cell_rd;
    assign mem_raddr = cmd.cell_rd ? start_addr :
                       (probe_reg == PROBE_CUR) ? top_reg : nb_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    // path stack
    logic [AW-1:0] stk_mem [CELLS];
    logic          stk_we;
    logic [SIW-1:0] stk_waddr;
    logic [AW-1:0] stk_wdata;
    logic          stk_re;
    logic [SIW-1:0] stk_raddr;

    assign stk_we    = cmd.start_init | cmd.carve;
    assign stk_waddr = cmd.start_init ? SIW'(0) : depth_reg[SIW-1:0];
    assign stk_wdata = cmd.start_init ? start_addr : nb_addr;
    assign stk_re    = cmd.capture && (depth_reg >= DW'(2));
    assign stk_raddr = SIW'(depth_reg - DW'(2));

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            probe_reg     <= '0;
            depth_reg     <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.capture)
            begin
                probe_reg <= '0;
            end
            else if (cmd.probe)
            begin
                probe_reg <= probe_reg + 3'd1;
            end
            if (cmd.start_init)
            begin
                depth_reg <= DW'(1);
                top_reg   <= start_addr;
            end
            else if (cmd.carve)
            begin
                depth_reg <= depth_reg + DW'(1);
                top_reg   <= nb_addr;
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_reg - DW'(1);
                top_reg   <= stk_rd_reg;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe && (probe_reg != '0))
        begin
            free_reg[pidx] <= in_grid[pidx] & ~rd_data_reg[EW-1];
        end
        if (cmd.pick)
        begin
            dir_reg <= mbg_pkg::dir_t'(dir_pick);
        end
    end

    // result register
    logic [mbg_pkg::EVENT_W-1:0] event_reg;
    logic [PW-1:0]               from_x_reg;
    logic [PW-1:0]               from_y_reg;
    logic [PW-1:0]               to_x_reg;
    logic [PW-1:0]               to_y_reg;
    logic [mbg_pkg::DIR_W-1:0]   direction_reg;
    logic [WW-1:0]               wall_bits_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            event_reg     <= cmd.out_event;
            from_x_reg    <= '0;
            from_y_reg    <= '0;
            to_x_reg      <= '0;
            to_y_reg      <= '0;
            direction_reg <= '0;
            wall_bits_reg <= '0;
            case (cmd.out_event)
                mbg_pkg::EV_STARTED:
                begin
                    from_x_reg <= PW'(x_reg);
                    from_y_reg <= PW'(y_reg);
                end
                mbg_pkg::EV_CARVED:
                begin
                    from_x_reg    <= PW'(top_x);
                    from_y_reg    <= PW'(top_y);
                    to_x_reg      <= PW'(nb_x);
                    to_y_reg      <= PW'(nb_y);
                    direction_reg <= dir_reg;
                end
                mbg_pkg::EV_BACKTRACKED:
                begin
                    from_x_reg <= PW'(top_x);
                    from_y_reg <= PW'(top_y);
                end
                mbg_pkg::EV_READ:
                begin
                    from_x_reg    <= PW'(x_reg);
                    from_y_reg    <= PW'(y_reg);
                    wall_bits_reg <= rd_data_reg[WW-1:0];
                end
                default: ;
            endcase
        end
    end

    assign item.ready       = cmd.in_ready;
    assign result.valid     = out_valid_reg;
    assign result.event_res = event_reg;
    assign result.from_x    = from_x_reg;
    assign result.from_y    = from_y_reg;
    assign result.to_x      = to_x_reg;
    assign result.to_y      = to_y_reg;
    assign result.direction = direction_reg;
    assign result.wall_bits = wall_bits_reg;

    assign status.in_valid   = item.valid;
    assign status.op         = item.operation;
    assign status.clr_done   = &clr_reg;
    assign status.depth_zero = (depth_reg == '0);
    assign status.probe_last = (probe_reg == PROBE_CUR);
    assign status.can_carve  = (free_cnt != '0) && (int'(depth_reg) < CELLS);
    assign status.out_free   = ~out_valid_reg | result.ready;

endmodule

@@ rtl/maze_backtracker_generator_core.sv @@
// step: 5 cell-memory probe reads (neighbours, then current cell), pick, then carve or pop;
//   next item taken after the result is loaded; a step on an empty stack gives EV_FINISHED
// read: a cell-memory read, then the result; start: clears 2**(clog2(W)+clog2(H)) cells
// one transaction at a time; a waiting result holds back only the final state
// reset: stack empty, grid height and width 32; a clearing pass over 2**(clog2(W)+clog2(H))
//   cells leaves all cells unvisited with walls closed and takes no item meanwhile
module maze_backtracker_generator_core #(
    parameter int MAX_WIDTH  = mbg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mbg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]     cfg_data,
    mbg_in_if.sink                        item,
    mbg_out_if.source                     result
);

    mbg_pkg::cmd_t    cmd;
    mbg_pkg::status_t status;

    mbg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mbg_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
